// File: sv/tcf_pkg.sv
// shared types and constants for the text console formatter
`default_nettype none
package tcf_pkg;
	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int COL_W = 7;
	localparam int ROW_W = 5;
	localparam int ADDR_W = 11;
	localparam int CELL_W = 16;
	localparam int DIGITS = 10;

	localparam logic [1:0] OP_FORMAT = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LOW_D = 8'h64;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X = 8'h58;
	localparam logic [7:0] CH_LOW_C = 8'h63;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIGIT,
		ST_PUT,
		ST_PUT2,
		ST_NEWLINE,
		ST_SCROLL_RD,
		ST_SCROLL_WR,
		ST_FILL,
		ST_CLEAR,
		ST_READ,
		ST_READ2,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		CONV_DEC,
		CONV_LHEX,
		CONV_UHEX
	} conv_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic digit_start;
		logic digit_step;
		logic put;
		logic put_second;
		logic newline;
		logic home_col;
		logic scroll_start;
		logic scroll_rd;
		logic scroll_wr;
		logic fill_start;
		logic fill_wr;
		logic clear_start;
		logic clear_wr;
		logic read_issue;
		logic read_capture;
		logic set_pending;
		logic clr_pending;
		logic result_load;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic pending;
		logic digits_done;
		logic digit_left;
		logic need_scroll;
		logic sweep_last;
		logic two_chars;
	} stat_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
		logic [7:0] r;
		if (d < 4'd10) r = CH_ZERO + {4'd0, d};
		else if (upper) r = 8'h37 + {4'd0, d};
		else r = 8'h57 + {4'd0, d};
		return r;
	endfunction
endpackage
`default_nettype wire

// File: sv/tcf_ram.sv
// generic single-port ram with registered read
`default_nettype none
module tcf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// File: sv/tcf_ctrl.sv
// controller state machine sequencing each word
`default_nettype none
module tcf_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_take,
	input wire logic [1:0] op,
	input wire logic [7:0] fbyte,
	input wire logic out_free,
	input wire tcf_pkg::stat_t stat,
	output tcf_pkg::ctrl_t ctrl,
	output logic busy
);
	import tcf_pkg::*;

	state_t state_q, state_d;
	logic [1:0] op_q;
	logic [7:0] byte_q;
	logic second_q, second_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			second_q <= second_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_FORMAT;
			byte_q <= CH_NUL;
		end else if (in_take) begin
			op_q <= op;
			byte_q <= fbyte;
		end
	end

	always_comb begin
		state_d = state_q;
		second_d = second_q;
		ctrl = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (in_take) begin
					ctrl.load = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				second_d = 1'b0;
				if (op_q == OP_CLEAR) begin
					ctrl.clear_start = 1'b1;
					ctrl.clr_pending = 1'b1;
					state_d = ST_CLEAR;
				end else if (op_q == OP_READ) begin
					ctrl.read_issue = 1'b1;
					state_d = ST_READ;
				end else if (op_q != OP_FORMAT) begin
					state_d = ST_DONE;
				end else if (stat.pending) begin
					ctrl.clr_pending = 1'b1;
					if (byte_q == CH_NUL) state_d = ST_DONE;
					else if (byte_q == CH_LOW_D || byte_q == CH_LOW_X || byte_q == CH_UP_X) begin
						ctrl.digit_start = 1'b1;
						state_d = ST_DIGIT;
					end else state_d = ST_PUT;
				end else if (byte_q == CH_NUL || byte_q == CH_CR) begin
					if (byte_q == CH_CR) ctrl.home_col = 1'b1;
					state_d = ST_DONE;
				end else if (byte_q == CH_PERCENT) begin
					ctrl.set_pending = 1'b1;
					state_d = ST_DONE;
				end else if (byte_q == CH_LF) begin
					state_d = ST_NEWLINE;
				end else state_d = ST_PUT;
			end
			ST_DIGIT: begin
				ctrl.digit_step = 1'b1;
				if (stat.digits_done) state_d = ST_PUT;
			end
			ST_PUT: begin
				ctrl.put = 1'b1;
				ctrl.put_second = second_q;
				if (stat.need_scroll) begin
					ctrl.scroll_start = 1'b1;
					state_d = ST_SCROLL_RD;
				end else state_d = ST_PUT2;
			end
			ST_PUT2: begin
				if (stat.two_chars && !second_q) begin
					second_d = 1'b1;
					state_d = ST_PUT;
				end else if (stat.digit_left) begin
					state_d = ST_PUT;
				end else state_d = ST_DONE;
			end
			ST_NEWLINE: begin
				ctrl.newline = 1'b1;
				if (stat.need_scroll) begin
					ctrl.scroll_start = 1'b1;
					state_d = ST_SCROLL_RD;
				end else state_d = ST_DONE;
			end
			ST_SCROLL_RD: begin
				ctrl.scroll_rd = 1'b1;
				state_d = ST_SCROLL_WR;
			end
			ST_SCROLL_WR: begin
				ctrl.scroll_wr = 1'b1;
				if (stat.sweep_last) begin
					ctrl.fill_start = 1'b1;
					state_d = ST_FILL;
				end else state_d = ST_SCROLL_RD;
			end
			ST_FILL: begin
				ctrl.fill_wr = 1'b1;
				if (stat.sweep_last) state_d = ST_PUT2;
			end
			ST_CLEAR: begin
				ctrl.clear_wr = 1'b1;
				if (stat.sweep_last) state_d = (op_q == OP_CLEAR) ? ST_DONE : ST_IDLE;
			end
			// hold the read address so the registered read still shows the cell
			ST_READ: begin
				ctrl.read_issue = 1'b1;
				state_d = ST_READ2;
			end
			ST_READ2: begin
				ctrl.read_capture = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					ctrl.result_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// File: sv/tcf_datapath.sv
// cursor, digit buffer, sweep counter and screen memory
`default_nettype none
module tcf_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire tcf_pkg::ctrl_t ctrl,
	input wire logic [1:0] op,
	input wire logic [7:0] fbyte,
	input wire logic [31:0] arg,
	input wire logic [10:0] cidx,
	input wire logic [7:0] attr,
	output tcf_pkg::stat_t stat,
	output logic [6:0] col,
	output logic [4:0] row,
	output logic [3:0] written,
	output logic scrolled,
	output logic [15:0] rcell
);
	import tcf_pkg::*;

	logic [7:0] byte_q;
	logic [31:0] val_q;
	logic [10:0] cidx_q;
	conv_t conv_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic pend_q;
	logic [3:0] written_q;
	logic scrolled_q;
	logic [15:0] rcell_q;
	logic [3:0] dig_q [DIGITS];
	logic [3:0] ndig_q;
	logic [ADDR_W-1:0] sw_q;
	logic conv_num_q, conv_chr_q, conv_pct_q;
	logic arst_done_q;

	logic we;
	logic [ADDR_W-1:0] addr;
	logic [CELL_W-1:0] wdata, rdata;

	tcf_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	// radix split: div by 10 via reciprocal multiply for decimal, or by 16 via shift for hex
	logic [31:0] quo;
	logic [3:0] rem;
	logic [63:0] prod;
	always_comb begin
		prod = val_q * 64'hCCCCCCCD;
		if (conv_q == CONV_DEC) begin
			quo = 32'(prod >> 35);
			rem = 4'(val_q - quo * 32'd10);
		end else begin
			quo = val_q >> 4;
			rem = val_q[3:0];
		end
	end

	logic [ADDR_W-1:0] cur_idx;
	assign cur_idx = ADDR_W'(row_q * COLUMNS) + ADDR_W'(col_q);

	logic [7:0] put_ch;
	always_comb begin
		if (conv_num_q) put_ch = hex_char(dig_q[ndig_q - 4'd1], conv_q == CONV_UHEX);
		else if (conv_chr_q) put_ch = val_q[7:0];
		else if (stat.two_chars) put_ch = ctrl.put_second ? byte_q : CH_PERCENT;
		else put_ch = byte_q;
	end

	always_comb begin
		we = 1'b0;
		addr = cur_idx;
		wdata = {attr, put_ch};
		if (ctrl.put) we = 1'b1;
		else if (ctrl.scroll_rd) addr = sw_q + ADDR_W'(COLUMNS);
		else if (ctrl.scroll_wr) begin
			we = 1'b1; addr = sw_q; wdata = rdata;
		end else if (ctrl.fill_wr || ctrl.clear_wr) begin
			we = 1'b1; addr = sw_q;
			wdata = {ctrl.clear_wr && !arst_done_q ? 8'd0 : attr, CH_SPACE};
		end else if (ctrl.read_issue) addr = cidx_q;
	end

	logic at_last_col, at_last_row;
	assign at_last_col = col_q == COL_W'(COLUMNS - 1);
	assign at_last_row = row_q == ROW_W'(ROWS - 1);

	always_comb begin
		stat.pending = pend_q;
		stat.digits_done = (quo == 32'd0) || (ndig_q == 4'(DIGITS - 1));
		stat.digit_left = conv_num_q && ndig_q != 4'd0;
		stat.need_scroll = ctrl.newline ? at_last_row : (at_last_col && at_last_row);
		stat.sweep_last = ctrl.scroll_wr ? (sw_q == ADDR_W'(CELL_COUNT - COLUMNS - 1))
			: (sw_q == ADDR_W'(CELL_COUNT - 1));
		stat.two_chars = !conv_num_q && !conv_chr_q && conv_pct_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= fbyte;
			val_q <= arg;
			cidx_q <= cidx;
			written_q <= '0;
			scrolled_q <= 1'b0;
			rcell_q <= '0;
			ndig_q <= '0;
			conv_num_q <= 1'b0;
			conv_chr_q <= 1'b0;
			conv_pct_q <= 1'b0;
			conv_q <= (fbyte == CH_LOW_D) ? CONV_DEC : (fbyte == CH_UP_X ? CONV_UHEX : CONV_LHEX);
		end
		if (ctrl.clr_pending && pend_q && op == OP_FORMAT) begin
			conv_num_q <= byte_q == CH_LOW_D || byte_q == CH_LOW_X || byte_q == CH_UP_X;
			conv_chr_q <= byte_q == CH_LOW_C;
			conv_pct_q <= !(byte_q == CH_LOW_D || byte_q == CH_LOW_X || byte_q == CH_UP_X
				|| byte_q == CH_LOW_C);
		end
		if (ctrl.digit_step) begin
			dig_q[ndig_q] <= rem;
			ndig_q <= ndig_q + 4'd1;
			val_q <= quo;
		end
		if (ctrl.put) begin
			written_q <= written_q + 4'd1;
			if (conv_num_q) ndig_q <= ndig_q - 4'd1;
		end
		if (ctrl.scroll_start) scrolled_q <= 1'b1;
		if (ctrl.read_capture) rcell_q <= (cidx_q < ADDR_W'(CELL_COUNT)) ? rdata : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pend_q <= 1'b0;
			arst_done_q <= 1'b0;
			sw_q <= '0;
		end else begin
			if (ctrl.clear_wr && stat.sweep_last) arst_done_q <= 1'b1;
			if (ctrl.set_pending) pend_q <= 1'b1;
			else if (ctrl.clr_pending) pend_q <= 1'b0;
			if (ctrl.scroll_start || ctrl.fill_start || ctrl.clear_start) begin
				sw_q <= ctrl.fill_start ? ADDR_W'(CELL_COUNT - COLUMNS) : '0;
			end else if (ctrl.scroll_wr || ctrl.fill_wr || ctrl.clear_wr) begin
				sw_q <= sw_q + ADDR_W'(1);
			end
			if (ctrl.clear_start) begin
				col_q <= '0; row_q <= '0;
			end else if (ctrl.newline) begin
				col_q <= '0;
				if (!at_last_row) row_q <= row_q + ROW_W'(1);
			end else if (ctrl.put) begin
				if (!at_last_col) col_q <= col_q + COL_W'(1);
				else begin
					col_q <= '0;
					if (!at_last_row) row_q <= row_q + ROW_W'(1);
				end
			end else if (ctrl.home_col) begin
				col_q <= '0;
			end
		end
	end

	assign col = col_q;
	assign row = row_q;
	assign written = written_q;
	assign scrolled = scrolled_q;
	assign rcell = rcell_q;
endmodule
`default_nettype wire

// File: sv/text_console_formatter.sv
// Text console: one word in, one result out. Each scroll copies every row but the first
// up by one row and blanks the last row through the single-port screen memory. After
// reset the block runs a clearing pass over all COLUMNS*ROWS cells before accepting
// words.
`default_nettype none
module text_console_formatter (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] opcode,
	input wire logic [7:0] format_byte,
	input wire logic [31:0] argument_value,
	input wire logic [10:0] cell_index,
	output logic out_valid,
	input wire logic out_stall,
	output logic [6:0] cursor_column,
	output logic [4:0] cursor_row,
	output logic [3:0] cells_written,
	output logic scrolled,
	output logic [15:0] read_cell
);
	import tcf_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	logic busy, in_take, out_free;
	logic [7:0] attr_q;
	logic [1:0] op_q;
	logic [6:0] col;
	logic [4:0] row;
	logic [3:0] wr;
	logic sc;
	logic [15:0] rc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) attr_q <= '0;
		else if (cfg_we) attr_q <= cfg_wdata;
	end

	assign in_stall = busy;
	assign in_take = in_valid && !busy;
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk) if (in_take) op_q <= opcode;

	tcf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_take(in_take), .op(opcode),
		.fbyte(format_byte), .out_free(out_free), .stat(stat), .ctrl(ctrl), .busy(busy)
	);

	tcf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .op(op_q), .fbyte(format_byte),
		.arg(argument_value), .cidx(cell_index), .attr(attr_q), .stat(stat),
		.col(col), .row(row), .written(wr), .scrolled(sc), .rcell(rc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (ctrl.result_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.result_load) begin
			cursor_column <= col;
			cursor_row <= row;
			cells_written <= wr;
			scrolled <= sc;
			read_cell <= rc;
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> busy) else $error("took a word while busy");
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		col < 7'(COLUMNS) && row < 5'(ROWS)) else $error("cursor off screen");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.result_load |=> out_valid) else $error("result lost");
endmodule
`default_nettype wire

// File: dv/tb_text_console_formatter.sv
// testbench for the text console formatter: directed and random words checked against a predictor
`default_nettype none
module tb_text_console_formatter;
	import tcf_pkg::*;

	localparam int LIMIT_CYCLES = 40000000;

	typedef struct packed {
		logic [6:0] col;
		logic [4:0] row;
		logic [3:0] written;
		logic scr;
		logic [15:0] rd;
	} cursor_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = '0;
	logic [7:0] format_byte = '0;
	logic [31:0] argument_value = '0;
	logic [10:0] cell_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [6:0] cursor_column;
	logic [4:0] cursor_row;
	logic [3:0] cells_written;
	logic scrolled;
	logic [15:0] read_cell;

	text_console_formatter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.format_byte(format_byte),
		.argument_value(argument_value),
		.cell_index(cell_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cursor_column(cursor_column),
		.cursor_row(cursor_row),
		.cells_written(cells_written),
		.scrolled(scrolled),
		.read_cell(read_cell)
	);

	// predicted console state
	logic [15:0] screen_model [CELL_COUNT];
	int unsigned cur_col, cur_row;
	logic pct_waiting;
	logic [7:0] attr_model;
	int unsigned word_cells;
	logic word_scrolled;

	cursor_report_t report_q[$];
	int fail_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_cycles = 0;
	int unsigned cycle_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stall, with a long hold-off when asked for
	always @(posedge clk) begin
		if (rx_hold_cycles > 0) begin
			rx_hold_cycles <= rx_hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cursor_report_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (report_q.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				exp_r = report_q.pop_front();
				if (cursor_column !== exp_r.col) begin
					$error("cursor_column exp %0d got %0d", exp_r.col, cursor_column);
					fail_count++;
				end
				if (cursor_row !== exp_r.row) begin
					$error("cursor_row exp %0d got %0d", exp_r.row, cursor_row);
					fail_count++;
				end
				if (cells_written !== exp_r.written) begin
					$error("cells_written exp %0d got %0d", exp_r.written, cells_written);
					fail_count++;
				end
				if (scrolled !== exp_r.scr) begin
					$error("scrolled exp %0d got %0d", exp_r.scr, scrolled);
					fail_count++;
				end
				if (read_cell !== exp_r.rd) begin
					$error("read_cell exp %h got %h", exp_r.rd, read_cell);
					fail_count++;
				end
			end
		end
	end

	function automatic logic [15:0] blank_word();
		return {attr_model, CH_SPACE};
	endfunction

	function automatic void scroll_screen();
		for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
			screen_model[i] = screen_model[i + COLUMNS];
		for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
			screen_model[i] = blank_word();
		cur_col = 0;
		cur_row = ROWS - 1;
		word_scrolled = 1'b1;
	endfunction

	function automatic void put_glyph(logic [7:0] ch);
		screen_model[cur_row * COLUMNS + cur_col] = {attr_model, ch};
		word_cells++;
		cur_col++;
		if (cur_col >= COLUMNS) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= ROWS)
			scroll_screen();
	endfunction

	function automatic void put_value(logic [31:0] v, int unsigned base, logic upper);
		logic [7:0] digit_buf [10];
		int n;
		int unsigned d;
		n = 0;
		if (v == 0) begin
			put_glyph(CH_ZERO);
			return;
		end
		while (v != 0) begin
			d = v % base;
			if (d < 10) digit_buf[n] = CH_ZERO + 8'(d);
			else digit_buf[n] = (upper ? 8'h41 : 8'h61) + 8'(d - 10);
			n++;
			v = v / base;
		end
		while (n > 0) begin
			n--;
			put_glyph(digit_buf[n]);
		end
	endfunction

	function automatic void format_char(logic [7:0] b, logic [31:0] arg);
		if (pct_waiting) begin
			pct_waiting = 1'b0;
			if (b == CH_NUL) return;
			if (b == CH_LOW_D) put_value(arg, 10, 1'b1);
			else if (b == CH_LOW_X) put_value(arg, 16, 1'b0);
			else if (b == CH_UP_X) put_value(arg, 16, 1'b1);
			else if (b == CH_LOW_C) put_glyph(arg[7:0]);
			else begin
				put_glyph(CH_PERCENT);
				put_glyph(b);
			end
			return;
		end
		if (b == CH_NUL) return;
		if (b == CH_PERCENT) pct_waiting = 1'b1;
		else if (b == CH_LF) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= ROWS) scroll_screen();
		end else if (b == CH_CR) cur_col = 0;
		else put_glyph(b);
	endfunction

	function automatic void predict_word(logic [1:0] op, logic [7:0] b, logic [31:0] arg,
			logic [10:0] idx);
		cursor_report_t r;
		logic [15:0] rd;
		rd = '0;
		word_cells = 0;
		word_scrolled = 1'b0;
		if (op == OP_FORMAT) format_char(b, arg);
		else if (op == OP_CLEAR) begin
			for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = blank_word();
			cur_col = 0;
			cur_row = 0;
			pct_waiting = 1'b0;
		end else if (op == OP_READ) begin
			if (idx < CELL_COUNT) rd = screen_model[idx];
		end
		r.col = 7'(cur_col);
		r.row = 5'(cur_row);
		r.written = 4'(word_cells);
		r.scr = word_scrolled;
		r.rd = rd;
		report_q.push_back(r);
	endfunction

	// valid stays high across back-to-back words; lowered only for a gap
	task automatic send_word(logic [1:0] op, logic [7:0] b, logic [31:0] arg, logic [10:0] idx);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		format_byte <= b;
		argument_value <= arg;
		cell_index <= idx;
		do @(posedge clk); while (in_stall);
		predict_word(op, b, arg, idx);
	endtask

	task automatic drain_results();
		@(posedge clk);
		in_valid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_attribute(logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		attr_model = v;
	endtask

	task automatic test_directed();
		send_word(OP_READ, 8'h00, 32'h0, 11'd0);
		send_word(OP_READ, 8'h00, 32'h0, 11'd2047);
		send_word(OP_FORMAT, 8'hff, 32'h0, 11'h7ff);
		send_word(OP_FORMAT, CH_PERCENT, 32'h0, 11'd0);
		send_word(OP_FORMAT, CH_LOW_D, 32'hffffffff, 11'd0);
		send_word(OP_FORMAT, CH_PERCENT, 32'h0, 11'd0);
		send_word(OP_FORMAT, CH_LOW_D, 32'h0, 11'd0);
		send_word(OP_FORMAT, CH_PERCENT, 32'h0, 11'd0);
		send_word(OP_FORMAT, CH_LOW_X, 32'hdeadbeef, 11'd0);
		send_word(OP_FORMAT, CH_PERCENT, 32'h0, 11'd0);
		send_word(OP_FORMAT, CH_UP_X, 32'h0badf00d, 11'd0);
		send_word(OP_FORMAT, CH_PERCENT, 32'h0, 11'd0);
		send_word(OP_FORMAT, CH_LOW_C, 32'h12345600, 11'd0);
		send_word(OP_FORMAT, CH_PERCENT, 32'h0, 11'd0);
		send_word(OP_FORMAT, CH_PERCENT, 32'h0, 11'd0);
		send_word(OP_FORMAT, CH_PERCENT, 32'h0, 11'd0);
		send_word(OP_FORMAT, 8'h71, 32'h0, 11'd0);
		send_word(OP_FORMAT, CH_PERCENT, 32'h0, 11'd0);
		send_word(OP_FORMAT, CH_NUL, 32'h0, 11'd0);
		send_word(OP_FORMAT, CH_CR, 32'h0, 11'd0);
		send_word(OP_FORMAT, CH_LF, 32'h0, 11'd0);
		send_word(OP_NONE, 8'h41, 32'h0, 11'd5);
		send_word(OP_READ, 8'h00, 32'h0, 11'd1999);
		send_word(OP_READ, 8'h00, 32'h0, 11'd2000);
		drain_results();
		write_attribute(8'hff);
		send_word(OP_CLEAR, 8'h00, 32'h0, 11'd0);
		send_word(OP_FORMAT, 8'h5a, 32'h0, 11'd0);
		send_word(OP_READ, 8'h00, 32'h0, 11'd1);
		drain_results();
	endtask

	task automatic send_random_word();
		int pick;
		logic [31:0] arg;
		logic [7:0] b;
		pick = $urandom_range(99);
		arg = $urandom >> $urandom_range(31, 0);
		if (pick < 2) send_word(OP_CLEAR, 8'($urandom), arg, 11'($urandom));
		else if (pick < 10)
			send_word(OP_READ, 8'($urandom), arg,
				($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(CELL_COUNT - 1)));
		else if (pick < 12) send_word(OP_NONE, 8'($urandom), arg, 11'($urandom));
		else if (pick < 30) begin
			// a conversion: a percent sign, then a conversion byte that may also be a random one
			send_word(OP_FORMAT, CH_PERCENT, $urandom, 11'($urandom));
			case ($urandom_range(6))
				0: b = CH_LOW_D;
				1: b = CH_LOW_X;
				2: b = CH_UP_X;
				3: b = CH_LOW_C;
				4: b = CH_PERCENT;
				5: b = CH_NUL;
				default: b = 8'($urandom);
			endcase
			send_word(OP_FORMAT, b, arg, 11'($urandom));
		end else if (pick < 34) send_word(OP_FORMAT, CH_LF, arg, 11'($urandom));
		else if (pick < 37) send_word(OP_FORMAT, CH_CR, arg, 11'($urandom));
		else if (pick < 39) send_word(OP_FORMAT, CH_NUL, arg, 11'($urandom));
		else send_word(OP_FORMAT, 8'($urandom), arg, 11'($urandom));
	endtask

	task automatic test_random_phase(int tx_pct, int rx_pct, int count, logic [7:0] attr);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		write_attribute(attr);
		repeat (count) send_random_word();
		drain_results();
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_cycles = 400;
		repeat (40) send_random_word();
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {8'h00, CH_SPACE};
		cur_col = 0;
		cur_row = 0;
		pct_waiting = 1'b0;
		attr_model = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(36, 61, 320, 8'h00);
		test_random_phase(61, 36, 320, 8'($urandom));
		test_random_phase(0, 0, 360, 8'ha5);
		test_backpressure();
		drain_results();
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
sv/tcf_pkg.sv
sv/tcf_ram.sv
sv/tcf_ctrl.sv
sv/tcf_datapath.sv
sv/text_console_formatter.sv
dv/tb_text_console_formatter.sv
